// ----- hdl/dltq_pkg.sv -----
// ---------------------------------------------------------------------------
// dltq_pkg
// Shared types and codes for the delta-list timer queue: list entry layout,
// per-cycle cell control, command, result and status codes.
// ---------------------------------------------------------------------------
package dltq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int SW         = $clog2(NUM_TIMERS);      // list position index
  localparam int PW         = $clog2(NUM_TIMERS + 1);  // entry count
  localparam int MAX_RES    = 16;                      // expiries per tick
  localparam int KW         = $clog2(MAX_RES);
  localparam int IDW        = 4;
  localparam int TW         = 32;

  // input commands
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_INS  = 2'd0;
  localparam logic [1:0] KIND_REM  = 2'd1;
  localparam logic [1:0] KIND_EXP  = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_QUEUED     = 2'd1;
  localparam logic [1:0] ST_NOT_QUEUED = 2'd2;

  // cell operations
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;  // open a gap at pos, load new entry
  localparam logic [1:0] OP_DEL  = 2'd2;  // close the entry at pos
  localparam logic [1:0] OP_WDL  = 2'd3;  // overwrite delta at pos

  typedef struct packed {
    logic           vld;
    logic [IDW-1:0] id;
    logic [TW-1:0]  delta;
    logic [TW-1:0]  start;
  } entry_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [SW-1:0] pos;
    logic [TW-1:0] wdata;
    entry_t        ins;
  } cell_ctl_t;

endpackage

// ----- hdl/dltq_cell.sv -----
// ---------------------------------------------------------------------------
// dltq_cell
// One list position. Holds one entry and trades it with its neighbors on
// insert (shift toward the tail) and delete (shift toward the head).
// ---------------------------------------------------------------------------
module dltq_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [dltq_pkg::SW-1:0] i_idx,
  input  dltq_pkg::cell_ctl_t     ctl,
  input  dltq_pkg::entry_t        left,
  input  dltq_pkg::entry_t        right,
  output dltq_pkg::entry_t        q
);

  dltq_pkg::entry_t ent_r;
  dltq_pkg::entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    case (ctl.op)
      dltq_pkg::OP_INS: begin
        if (i_idx > ctl.pos) begin
          ent_nxt = left;
        end else if (i_idx == ctl.pos) begin
          ent_nxt = ctl.ins;
        end
      end
      dltq_pkg::OP_DEL: begin
        if (i_idx >= ctl.pos) begin
          ent_nxt = right;
        end
      end
      dltq_pkg::OP_WDL: begin
        if (i_idx == ctl.pos) begin
          ent_nxt.delta = ctl.wdata;
        end
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign q = ent_r;

endmodule

// ----- hdl/delta_list_timer_queue_unit.sv -----
// ---------------------------------------------------------------------------
// delta_list_timer_queue_unit
// Timer queue kept as a sorted delta list in a row of list cells.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one request = cmd, timer_id, amount.
//    cmd 0 inserts a timer for amount units, 1 removes it, 2 advances time.
//  - Output channel (out_valid/out_ready): one or more results per request,
//    out_last marks the final one. Insert, remove and plain ticks give one
//    result; a tick that expires timers gives one result per expired timer.
//  - One request is processed at a time; in_ready is high only when idle.
//  - Steps from request accept to out_valid: an insert into an empty queue
//    decodes and shifts in the entry; one before the head also cuts the
//    head's delta; else it walks positions 1 up to the landing place (at most
//    NUM_TIMERS - 1), one entry per cycle, and cuts a delta if it lands
//    before an entry. Remove: parallel id match in the cells, delta merge,
//    close. Tick and rejected requests: decode, then the results.
//  - Entries sit in list order, cell 0 is the head; an insert or delete
//    shifts every cell behind it by one position at once.
//  - A single output register holds the pending result; when the receiver
//    stalls, the sequencer holds back its next result until the register frees.
//  - Reset (rst_n low, synchronous) empties the list, clears the time
//    counters and drops any pending result. No clearing pass is needed.
// ---------------------------------------------------------------------------
module delta_list_timer_queue_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_cmd,
  input  logic [dltq_pkg::IDW-1:0]     in_timer_id,
  input  logic [dltq_pkg::TW-1:0]      in_amount,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_kind,
  output logic [1:0]                   out_status,
  output logic [dltq_pkg::IDW-1:0]     out_timer_id_res,
  output logic [dltq_pkg::TW-1:0]      out_elapsed,
  output logic                         out_last
);

  localparam int N  = dltq_pkg::NUM_TIMERS;
  localparam int SW = dltq_pkg::SW;
  localparam int PW = dltq_pkg::PW;
  localparam int KW = dltq_pkg::KW;
  localparam int TW = dltq_pkg::TW;
  localparam int IDW = dltq_pkg::IDW;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;  // decode the request
  localparam logic [3:0] S_INS_HEAD = 4'd2;  // compare against head remainder
  localparam logic [3:0] S_WALK     = 4'd3;  // one list entry per cycle
  localparam logic [3:0] S_ADJ      = 4'd4;  // cut the successor's delta
  localparam logic [3:0] S_PUT      = 4'd5;  // shift in the new entry
  localparam logic [3:0] S_RM       = 4'd6;  // merge delta into successor
  localparam logic [3:0] S_RM_DEL   = 4'd7;  // close the removed entry
  localparam logic [3:0] S_EXP      = 4'd8;  // pop expiring heads
  localparam logic [3:0] S_RESP     = 4'd9;  // single result out

  // ------------------------------------------------------------------
  // sequencer registers
  // ------------------------------------------------------------------
  logic [3:0]     state_r,   state_nxt;
  logic [1:0]     cmd_r,     cmd_nxt;
  logic [IDW-1:0] id_r,      id_nxt;
  logic [TW-1:0]  dur_r,     dur_nxt;    // amount, then remaining duration
  logic [TW-1:0]  adj_r,     adj_nxt;
  logic [TW-1:0]  he_r,      he_nxt;     // head elapsed
  logic [TW-1:0]  gt_r,      gt_nxt;     // global time
  logic [PW-1:0]  cnt_r,     cnt_nxt;
  logic [SW-1:0]  pos_r,     pos_nxt;
  logic [KW-1:0]  k_r,       k_nxt;
  logic [1:0]     kind_r,    kind_nxt;
  logic [1:0]     status_r,  status_nxt;
  logic [TW-1:0]  el_r,      el_nxt;

  // output register
  logic           ov_r,      ov_nxt;
  logic [1:0]     okind_r,   okind_nxt;
  logic [1:0]     ostat_r,   ostat_nxt;
  logic [IDW-1:0] oid_r,     oid_nxt;
  logic [TW-1:0]  oel_r,     oel_nxt;
  logic           olast_r,   olast_nxt;

  logic           out_free;
  logic           id_ok;
  logic [SW-1:0]  hit_pos;
  logic [SW-1:0]  pos_p1;
  logic [TW-1:0]  remain;
  logic [TW-1:0]  he_sum;
  logic           exp_last;

  // ------------------------------------------------------------------
  // cell row
  // ------------------------------------------------------------------
  dltq_pkg::cell_ctl_t ctl;
  dltq_pkg::entry_t    cell_q [N];
  dltq_pkg::entry_t    cell_l [N];
  dltq_pkg::entry_t    cell_rt[N];
  logic [N-1:0]        match;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_l[i] = '0;
    end else begin : g_mid
      assign cell_l[i] = cell_q[i-1];
    end
    if (i == N - 1) begin : g_last
      assign cell_rt[i] = '0;
    end else begin : g_inner
      assign cell_rt[i] = cell_q[i+1];
    end

    dltq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .i_idx (SW'(i)),
      .ctl   (ctl),
      .left  (cell_l[i]),
      .right (cell_rt[i]),
      .q     (cell_q[i])
    );

    assign match[i] = cell_q[i].vld && (cell_q[i].id == id_r);
  end

  assign out_free = !ov_r || out_ready;
  assign id_ok    = (32'(id_r) < N);
  assign pos_p1   = pos_r + SW'(1);
  assign remain   = cell_q[0].delta - he_r;
  assign he_sum   = he_r + dur_r;
  assign exp_last = (k_r == KW'(dltq_pkg::MAX_RES - 1)) || !cell_q[1].vld ||
                    (cell_q[1].delta != '0);

  // position of the matching entry (at most one matches)
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < N; i++) begin
      if (match[i]) begin
        hit_pos = hit_pos | SW'(i);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    id_nxt     = id_r;
    dur_nxt    = dur_r;
    adj_nxt    = adj_r;
    he_nxt     = he_r;
    gt_nxt     = gt_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    k_nxt      = k_r;
    kind_nxt   = kind_r;
    status_nxt = status_r;
    el_nxt     = el_r;

    ov_nxt     = ov_r && !out_ready;
    okind_nxt  = okind_r;
    ostat_nxt  = ostat_r;
    oid_nxt    = oid_r;
    oel_nxt    = oel_r;
    olast_nxt  = olast_r;

    ctl           = '0;
    ctl.op        = dltq_pkg::OP_HOLD;
    ctl.pos       = pos_r;
    ctl.wdata     = adj_r;
    ctl.ins.vld   = 1'b1;
    ctl.ins.id    = id_r;
    ctl.ins.delta = dur_r;
    ctl.ins.start = gt_r;

    in_ready = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          id_nxt    = in_timer_id;
          dur_nxt   = in_amount;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        kind_nxt   = cmd_r;
        status_nxt = dltq_pkg::ST_OK;
        el_nxt     = '0;
        state_nxt  = S_RESP;
        case (cmd_r)
          dltq_pkg::CMD_INSERT: begin
            if (!id_ok) begin
              status_nxt = dltq_pkg::ST_NOT_QUEUED;
            end else if (|match) begin
              status_nxt = dltq_pkg::ST_QUEUED;
            end else if (cnt_r == '0) begin
              pos_nxt   = '0;
              he_nxt    = '0;
              state_nxt = S_PUT;
            end else begin
              state_nxt = S_INS_HEAD;
            end
          end
          dltq_pkg::CMD_REMOVE: begin
            if (!id_ok || !(|match)) begin
              status_nxt = dltq_pkg::ST_NOT_QUEUED;
            end else begin
              pos_nxt   = hit_pos;
              state_nxt = S_RM;
            end
          end
          dltq_pkg::CMD_TICK: begin
            gt_nxt   = gt_r + dur_r;
            kind_nxt = dltq_pkg::KIND_TICK;
            if (cnt_r != '0 && he_sum >= cell_q[0].delta) begin
              // head_elapsed clears as the expiry pass starts
              he_nxt    = '0;
              k_nxt     = '0;
              state_nxt = S_EXP;
            end else begin
              he_nxt = he_sum;
            end
          end
          default: begin
            kind_nxt = dltq_pkg::KIND_TICK;
            id_nxt   = '0;
          end
        endcase
      end

      S_INS_HEAD: begin
        if (dur_r < remain) begin
          adj_nxt   = remain - dur_r;
          pos_nxt   = '0;
          he_nxt    = '0;
          state_nxt = S_ADJ;
        end else begin
          dur_nxt   = dur_r - remain;
          pos_nxt   = SW'(1);
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        if (PW'(pos_r) == cnt_r) begin
          state_nxt = S_PUT;
        end else if (dur_r < cell_q[pos_r].delta) begin
          adj_nxt   = cell_q[pos_r].delta - dur_r;
          state_nxt = S_ADJ;
        end else begin
          dur_nxt = dur_r - cell_q[pos_r].delta;
          pos_nxt = pos_p1;
        end
      end

      S_ADJ: begin
        ctl.op    = dltq_pkg::OP_WDL;
        state_nxt = S_PUT;
      end

      S_PUT: begin
        ctl.op     = dltq_pkg::OP_INS;
        cnt_nxt    = cnt_r + PW'(1);
        status_nxt = dltq_pkg::ST_OK;
        state_nxt  = S_RESP;
      end

      S_RM: begin
        el_nxt    = gt_r - cell_q[pos_r].start;
        ctl.pos   = pos_p1;
        ctl.wdata = cell_q[pos_p1].delta + cell_q[pos_r].delta;
        if (PW'(pos_r) + PW'(1) < cnt_r) begin
          ctl.op = dltq_pkg::OP_WDL;
        end
        state_nxt = S_RM_DEL;
      end

      S_RM_DEL: begin
        ctl.op     = dltq_pkg::OP_DEL;
        cnt_nxt    = cnt_r - PW'(1);
        status_nxt = dltq_pkg::ST_OK;
        state_nxt  = S_RESP;
      end

      S_EXP: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = dltq_pkg::KIND_EXP;
          ostat_nxt = dltq_pkg::ST_OK;
          oid_nxt   = cell_q[0].id;
          oel_nxt   = '0;
          olast_nxt = exp_last;
          ctl.op    = dltq_pkg::OP_DEL;
          ctl.pos   = '0;
          cnt_nxt   = cnt_r - PW'(1);
          k_nxt     = k_r + KW'(1);
          if (exp_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = kind_r;
          ostat_nxt = status_r;
          oid_nxt   = (kind_r == dltq_pkg::KIND_TICK) ? '0 : id_r;
          oel_nxt   = el_r;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      he_r    <= '0;
      gt_r    <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      he_r    <= he_nxt;
      gt_r    <= gt_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    id_r     <= id_nxt;
    dur_r    <= dur_nxt;
    adj_r    <= adj_nxt;
    pos_r    <= pos_nxt;
    k_r      <= k_nxt;
    kind_r   <= kind_nxt;
    status_r <= status_nxt;
    el_r     <= el_nxt;
    okind_r  <= okind_nxt;
    ostat_r  <= ostat_nxt;
    oid_r    <= oid_nxt;
    oel_r    <= oel_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid        = ov_r;
  assign out_kind         = okind_r;
  assign out_status       = ostat_r;
  assign out_timer_id_res = oid_r;
  assign out_elapsed      = oel_r;
  assign out_last         = olast_r;

endmodule
